### sv/greedy_independent_set_partition_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy independent set partition unit
// Shared concurrent-check shapes, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GREEDY_INDEPENDENT_SET_PARTITION_UNIT_ASSERT_SVH
`define GREEDY_INDEPENDENT_SET_PARTITION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GISP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define GISP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/gisp_pkg.sv
// ----------------------------------------------------------------------------
// gisp_pkg
// Types, constants and helpers of the greedy independent set partition unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gisp_pkg;

  localparam int MAX_NODES_DEF = 32;
  localparam int NODE_W        = 5;
  localparam int ROW_W         = 32;
  localparam int CNT_W         = 6;
  localparam int TDATA_W       = 40;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_APPLY,
    S_OUT
  } state_t;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [NODE_W-1:0] lowest_one(input logic [ROW_W-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NODE_W'(i);
      end
    end
    return idx;
  endfunction

  // Mask of the low n bits, n in 0..32.
  function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n[CNT_W-1]) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << n[NODE_W-1:0]) - ROW_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### sv/greedy_independent_set_partition_unit.sv
// ----------------------------------------------------------------------------
// greedy_independent_set_partition_unit
// Loads adjacency rows into a row store; on the row of the highest node in
// use, splits the nodes into independent sets by greedy rounds and sends
// one member mask per round.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat / fields (low bit up)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata: row_index[4:0], adjacency_row[36:5], zero pad
//  m_axis    out  tdata: set_index[4:0], member_mask[36:5], zero pad;
//                 tlast: last_set
//  cfg       in   cfg_wen / cfg_wdata: node_count (6 bits)
//
//  The beat of the highest node in use (node_count-1, node_count capped at the
//  store size) starts a partition: each chosen node passes through S_PICK
//  (encode + row read) and then S_APPLY (apply the row), and each round ends
//  in S_OUT, which holds while m_axis_tready is low.
//  s_axis_tready is low from the trigger beat until the last set is taken.
//  rst is synchronous; the row store is never cleared and needs no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_independent_set_partition_unit #(
  parameter int MAX_NODES = gisp_pkg::MAX_NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: node_count
  input  wire logic                          cfg_wen,
  input  wire logic [gisp_pkg::CNT_W-1:0]    cfg_wdata,
  // row input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [gisp_pkg::TDATA_W-1:0]  s_axis_tdata,  // row_index, adjacency_row
  // set output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [gisp_pkg::TDATA_W-1:0]  m_axis_tdata,  // set_index, member_mask
  output logic                               m_axis_tlast   // last_set
);

  localparam int NODE_W = gisp_pkg::NODE_W;
  localparam int ROW_W  = gisp_pkg::ROW_W;
  localparam int CNT_W  = gisp_pkg::CNT_W;
  localparam int AW     = $clog2(MAX_NODES);
  // usable node count never exceeds the store or the mask width
  localparam int CAP    = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  gisp_pkg::state_t   state, state_next;
  logic [CNT_W-1:0]   node_count;
  logic [ROW_W-1:0]   pool, pool_next;       // nodes still open this round
  logic [ROW_W-1:0]   nxt_pool, nxt_pool_next; // nodes pushed to next round
  logic [ROW_W-1:0]   set_mask, set_mask_next; // members of this round
  logic [NODE_W-1:0]  round, round_next;
  logic [NODE_W-1:0]  pick_idx;                // node whose row is in flight

  // --------------------------------------------------------------------------
  // input beat decode
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0]  in_row_index;
  logic [ROW_W-1:0]   in_row;
  logic               in_beat;
  logic               store_ok;
  logic [CNT_W-1:0]   n_eff;
  logic [ROW_W-1:0]   valid_mask;
  logic               trigger;

  assign in_row_index = s_axis_tdata[NODE_W-1:0];
  assign in_row       = s_axis_tdata[NODE_W+ROW_W-1:NODE_W];
  assign in_beat      = s_axis_tvalid && s_axis_tready;
  assign store_ok     = (32'(in_row_index) < MAX_NODES);

  assign n_eff      = (32'(node_count) > CAP) ? CNT_W'(CAP) : node_count;
  assign valid_mask = gisp_pkg::low_mask(n_eff);
  assign trigger    = (n_eff != '0) && ({1'b0, in_row_index} == (n_eff - CNT_W'(1)));

  // --------------------------------------------------------------------------
  // row store
  // --------------------------------------------------------------------------
  logic               ram_we;
  logic [NODE_W-1:0]  ram_node;
  logic [AW-1:0]      ram_addr;
  logic [ROW_W-1:0]   ram_rdata;

  // node number to store address; the address width follows MAX_NODES
  assign ram_addr = AW'(ram_node);

  gisp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_row),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // round datapath
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0]  low_idx;
  logic [ROW_W-1:0]   low_bit;
  logic [ROW_W-1:0]   moved;
  logic [ROW_W-1:0]   pool_after;
  logic [ROW_W-1:0]   nxt_after;

  assign low_idx    = gisp_pkg::lowest_one(pool);
  assign low_bit    = ROW_W'(1) << low_idx;
  // chosen bit already left the pool, so self loops drop out here
  assign moved      = ram_rdata & valid_mask & pool;
  assign pool_after = pool & ~moved;
  assign nxt_after  = nxt_pool | moved;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      gisp_pkg::S_IDLE: begin
        if (in_beat && trigger) state_next = gisp_pkg::S_PICK;
      end
      gisp_pkg::S_PICK: begin
        state_next = gisp_pkg::S_APPLY;
      end
      gisp_pkg::S_APPLY: begin
        state_next = (pool_after == '0) ? gisp_pkg::S_OUT : gisp_pkg::S_PICK;
      end
      gisp_pkg::S_OUT: begin
        if (m_axis_tready) begin
          state_next = (nxt_pool == '0) ? gisp_pkg::S_IDLE : gisp_pkg::S_PICK;
        end
      end
      default: state_next = gisp_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ram_we        = 1'b0;
    ram_node      = in_row_index;
    pool_next     = pool;
    nxt_pool_next = nxt_pool;
    set_mask_next = set_mask;
    round_next    = round;
    unique case (state)
      gisp_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = in_beat && store_ok;
        if (in_beat && trigger) begin
          pool_next     = valid_mask;
          nxt_pool_next = '0;
          set_mask_next = '0;
          round_next    = '0;
        end
      end
      gisp_pkg::S_PICK: begin
        ram_node      = low_idx;
        set_mask_next = set_mask | low_bit;
        pool_next     = pool & ~low_bit;
      end
      gisp_pkg::S_APPLY: begin
        ram_node      = pick_idx;
        pool_next     = pool_after;
        nxt_pool_next = nxt_after;
      end
      gisp_pkg::S_OUT: begin
        m_axis_tvalid = 1'b1;
        ram_node      = pick_idx;
        if (m_axis_tready) begin
          pool_next     = nxt_pool;
          nxt_pool_next = '0;
          set_mask_next = '0;
          round_next    = round + NODE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {{(gisp_pkg::TDATA_W - NODE_W - ROW_W){1'b0}}, set_mask, round};
  assign m_axis_tlast = (nxt_pool == '0);

  // --------------------------------------------------------------------------
  // register update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gisp_pkg::S_IDLE;
      node_count <= gisp_pkg::NODE_COUNT_RST;
      pool       <= '0;
      nxt_pool   <= '0;
      set_mask   <= '0;
      round      <= '0;
    end else begin
      state    <= state_next;
      pool     <= pool_next;
      nxt_pool <= nxt_pool_next;
      set_mask <= set_mask_next;
      round    <= round_next;
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gisp_pkg::S_PICK) begin
      pick_idx <= low_idx;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
`include "greedy_independent_set_partition_unit_assert.svh"

  `GISP_ASSERT_NOW(a_sets_disjoint, state != gisp_pkg::S_IDLE, ((set_mask & pool) == '0) && ((set_mask & nxt_pool) == '0) && ((pool & nxt_pool) == '0), "set, pool and next pool overlap")
  `GISP_ASSERT_NOW(a_set_nonempty, m_axis_tvalid, set_mask != '0, "empty set emitted")
  `GISP_ASSERT_NOW(a_set_in_range, m_axis_tvalid, (set_mask & ~valid_mask) == '0, "set holds node beyond node count")
  `GISP_ASSERT_NEXT(a_last_frees_input, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "input not reopened after last set")

endmodule

`default_nettype wire

### sv/gisp_ram.sv
// ----------------------------------------------------------------------------
// gisp_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gisp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### dv/tb_greedy_independent_set_partition_unit.sv
// ----------------------------------------------------------------------------
// tb_greedy_independent_set_partition_unit
// Self-checking bench: streams adjacency rows into the unit, predicts the
// greedy independent-set partition on every trigger row and scoreboards the
// member-mask beats in order, across node_count settings and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_greedy_independent_set_partition_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_W        = gisp_pkg::NODE_W;
  localparam int ROW_W         = gisp_pkg::ROW_W;
  localparam int CNT_W         = gisp_pkg::CNT_W;
  localparam int TDATA_W       = gisp_pkg::TDATA_W;
  localparam int MAX_NODES_DEF = gisp_pkg::MAX_NODES_DEF;

  localparam int SETTLE_CYCLES = 8;     // unit returns to idle well within this
  localparam int STALL_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int PHASES        = 12;
  localparam int PHASE_ROWS    = 18;    // approx. row beats per random phase
  localparam int MAX_REPORTS   = 10;
  localparam int PAD_W         = TDATA_W - NODE_W - ROW_W;

  // one row beat
  typedef struct packed {
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  adjacency_row;
  } row_beat_t;

  // one independent set as the unit should send it
  typedef struct packed {
    logic [NODE_W-1:0] set_index;
    logic [ROW_W-1:0]  member_mask;
    logic              last_set;
  } node_set_t;

  // shapes of random adjacency rows
  typedef enum int {
    ROW_RANDOM,
    ROW_SPARSE,
    ROW_DENSE,
    ROW_EMPTY,
    ROW_FULL
  } row_shape_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_wen       = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata     = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;  // row_index, adjacency_row, pad
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // set_index, member_mask, pad
  logic               m_axis_tlast;        // last_set

  greedy_independent_set_partition_unit #(
    .MAX_NODES(MAX_NODES_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  row_beat_t        rows_pending[$];     // rows waiting for the driver
  node_set_t        expected_sets[$];    // sets predicted, not yet seen
  logic [ROW_W-1:0] adj_rows[MAX_NODES_DEF];
  logic [CNT_W-1:0] node_count_model = gisp_pkg::NODE_COUNT_RST;

  int send_idle_pct = 12;
  int recv_idle_pct = 59;
  int mismatches    = 0;
  int rows_sent     = 0;
  int sets_checked  = 0;
  int partitions    = 0;
  int longest_part  = 0;
  int cfg_writes    = 0;
  int stall_cycles  = 0;

  // --------------------------------------------------------------------------
  // Partition predictor: stores the row, and on the row of the highest node
  // in use runs greedy rounds over the stored rows.
  // --------------------------------------------------------------------------
  function automatic void predict_partition(input logic [NODE_W-1:0] ridx,
                                            input logic [ROW_W-1:0]  row);
    int               nodes;
    int               rounds;
    int               pick;
    logic [ROW_W-1:0] in_use;
    logic [ROW_W-1:0] pool;
    logic [ROW_W-1:0] next_pool;
    logic [ROW_W-1:0] members;
    logic [ROW_W-1:0] pick_mask;
    logic [ROW_W-1:0] moved;
    node_set_t        set_out;

    adj_rows[ridx] = row;
    // node_count above the store size folds down to the store size
    nodes = (node_count_model > CNT_W'(MAX_NODES_DEF)) ? MAX_NODES_DEF
                                                        : int'(node_count_model);
    if (nodes == 0 || int'(ridx) != nodes - 1) begin
      return;
    end

    in_use = (nodes >= ROW_W) ? '1 : ((ROW_W'(1) << nodes) - ROW_W'(1));
    pool   = in_use;
    rounds = 0;
    while (pool != '0 && rounds < 32) begin
      members   = '0;
      next_pool = '0;
      while (pool != '0) begin
        pick = 0;
        while (pick < ROW_W - 1 && !pool[pick]) begin
          pick++;
        end
        pick_mask = ROW_W'(1) << pick;
        members  |= pick_mask;
        pool     &= ~pick_mask;
        // neighbours still in the pool wait for a later round;
        // the self loop and bits beyond the graph drop out here
        moved      = adj_rows[pick] & ~pick_mask & in_use & pool;
        next_pool |= moved;
        pool      &= ~moved;
      end
      set_out.set_index   = NODE_W'(rounds);
      set_out.member_mask = members;
      set_out.last_set    = (next_pool == '0);
      expected_sets.push_back(set_out);
      rounds++;
      pool = next_pool;
    end
    partitions++;
    if (rounds > longest_part) begin
      longest_part = rounds;
    end
  endfunction

  // compare one received set against the oldest prediction
  function automatic void check_set(input node_set_t got);
    node_set_t want;
    if (expected_sets.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] unexpected set: idx=%0d mask=%h last=%0b",
                 $realtime, got.set_index, got.member_mask, got.last_set);
      end
      return;
    end
    want = expected_sets.pop_front();
    sets_checked++;
    if (got.set_index !== want.set_index || got.member_mask !== want.member_mask ||
        got.last_set !== want.last_set) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] set mismatch: exp idx=%0d mask=%h last=%0b,",
                 $realtime, want.set_index, want.member_mask, want.last_set);
        $display("    got idx=%0d mask=%h last=%0b",
                 got.set_index, got.member_mask, got.last_set);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Row driver: one NBA per cycle on tvalid; a new beat goes out only when the
  // slot is empty or the current beat is taken at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (rows_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        row_beat_t beat;
        beat = rows_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, beat.adjacency_row, beat.row_index};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // set receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every accepted row beat, check every accepted set beat.
  // A set never comes out in the cycle of its trigger row.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rows_sent++;
        predict_partition(s_axis_tdata[NODE_W-1:0], s_axis_tdata[NODE_W+ROW_W-1:NODE_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_set({m_axis_tdata[NODE_W-1:0], m_axis_tdata[NODE_W+ROW_W-1:NODE_W],
                   m_axis_tlast});
      end
    end
  end

  // Watchdog: ends the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d sets outstanding",
               $realtime, STALL_LIMIT, expected_sets.size());
      $display("** greedy_independent_set_partition_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_row(input int idx, input logic [ROW_W-1:0] row);
    row_beat_t beat;
    beat.row_index     = NODE_W'(idx);
    beat.adjacency_row = row;
    rows_pending.push_back(beat);
  endtask

  // Hold off until every row is taken and every set has come back, then let
  // the unit finish any non-trigger row write before touching the register.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (rows_pending.size() != 0 || s_axis_tvalid || expected_sets.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write; the unit is idle here so the predictor can follow at once
  task automatic write_node_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen          <= 1'b0;
    node_count_model  = value;
    cfg_writes++;
    @(negedge clk);
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    row_shape_t       shape;
    logic [ROW_W-1:0] row;
    shape = row_shape_t'($urandom_range(0, 4));
    case (shape)
      ROW_SPARSE: begin
        row = (ROW_W'(1) << $urandom_range(0, 31)) | (ROW_W'(1) << $urandom_range(0, 31));
      end
      ROW_DENSE: begin
        row = $urandom() | $urandom();
      end
      ROW_EMPTY: begin
        row = '0;
      end
      ROW_FULL: begin
        row = '1;
      end
      default: begin
        row = $urandom();
      end
    endcase
    return row;
  endfunction

  // Mostly well-formed frames (a few rows of the graph, then the trigger
  // row), with some stray rows anywhere in the store mixed in.
  task automatic load_random_phase();
    int nodes;
    int budget;
    int extra;
    nodes  = (node_count_model > CNT_W'(MAX_NODES_DEF)) ? MAX_NODES_DEF
                                                         : int'(node_count_model);
    budget = PHASE_ROWS;
    while (budget > 0) begin
      if (nodes == 0 || $urandom_range(9) == 0) begin
        queue_row($urandom_range(0, 31), random_row());
        budget--;
      end else begin
        extra = $urandom_range(0, 5);
        for (int i = 0; i < extra; i++) begin
          queue_row($urandom_range(0, nodes - 1), random_row());
        end
        queue_row(nodes - 1, random_row());
        budget -= extra + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] node_plan[PHASES];

    node_plan = '{6'd32, 6'd1, 6'd0, 6'd2, 6'd63, 6'd9,
                  6'd32, 6'd7, 6'd40, 6'd17, 6'd3, 6'd32};
    node_plan[5] = CNT_W'($urandom_range(3, 31));
    node_plan[9] = CNT_W'($urandom_range(3, 31));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed. At the reset count of 32 fill the whole store with a complete
    // graph: every row is written before any partition reads it, and the
    // trigger yields the longest partition, one node per set.
    for (int r = 0; r < MAX_NODES_DEF; r++) begin
      queue_row(r, '1);
    end
    drain();

    // single node: self loop and bits beyond the graph only
    write_node_count(6'd1);
    queue_row(0, '1);
    drain();

    // node count zero: rows are stored, nothing ever starts
    write_node_count(6'd0);
    queue_row(0, 32'h0000_0005);
    queue_row(31, '0);
    drain();

    // oversized count folds to 32; sparse rows on the top nodes
    write_node_count(6'd63);
    queue_row(30, '0);
    queue_row(31, 32'h8000_0001);
    drain();

    // two nodes joined by one directed edge
    write_node_count(6'd2);
    queue_row(0, 32'h0000_0002);
    queue_row(1, 32'hFFFF_FFFC);
    drain();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    // Each phase drains fully, so the sender pauses for all sets each time.
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 59;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_node_count(node_plan[p]);
      load_random_phase();
      drain();
    end

    if (expected_sets.size() != 0) begin
      mismatches += expected_sets.size();
      $display("%0d predicted sets never arrived", expected_sets.size());
    end

    $display("covered %0d row beats, %0d partitions, %0d sets checked (longest %0d sets)",
             rows_sent, partitions, sets_checked, longest_part);
    $display("%0d node_count writes incl. 0, 1, 2, 32 and oversized; %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("** greedy_independent_set_partition_unit: PASSED **");
    end else begin
      $display("** greedy_independent_set_partition_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### greedy_independent_set_partition_unit.f
+incdir+sv
sv/gisp_pkg.sv
sv/gisp_ram.sv
sv/greedy_independent_set_partition_unit.sv
dv/tb_greedy_independent_set_partition_unit.sv
